// ----- rtl/core/hse_pkg.sv -----
// package: shared types, constants and command structs of the hmac-sha1 engine
`timescale 1ns / 1ps
package hse_pkg;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;
	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5c;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [6:0] KEY_FULL = 7'd64;
	localparam logic [6:0] KEY_LONG = 7'd65;
	localparam logic [5:0] LEN_SLOT = 6'd56;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] ADD_ROUND = 7'd80;

	typedef enum logic [4:0] {
		S_KEY, S_KPAD, S_LKEY, S_LBYTE, S_INNER, S_DATA, S_OKEY, S_OIN,
		S_F80, S_FZERO, S_FLEN, S_FWAIT, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		CTX_LONGKEY, CTX_INNER, CTX_OUTER
	} ctx_t;

	typedef enum logic [3:0] {
		SRC_IN, SRC_HOLD, SRC_KEY, SRC_KEY_I, SRC_KEY_O, SRC_INNER,
		SRC_PAD80, SRC_ZERO, SRC_LEN
	} src_t;

	typedef struct packed {
		logic       hash_start;
		logic       absorb;
		src_t       src;
		logic [2:0] idx;
		logic       key_shift_in;
		logic       key_shift_zero;
		logic       key_load_digest;
		logic       hold_load;
		logic       inner_save;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic [5:0] fill;
	} status_t;

endpackage

// ----- rtl/core/hse_in_if.sv -----
// interface: input item channel
`timescale 1ns / 1ps
interface hse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_value;
	logic       is_key;
	logic       end_of_part;
	logic       carries_none;

	modport source (output valid, data_value, is_key, end_of_part, carries_none, input ready);
	modport sink (input valid, data_value, is_key, end_of_part, carries_none, output ready);
endinterface

// ----- rtl/core/hse_out_if.sv -----
// interface: digest word channel
`timescale 1ns / 1ps
interface hse_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;

	modport source (output valid, digest_word, word_number, final_word, input ready);
	modport sink (input valid, digest_word, word_number, final_word, output ready);
endinterface

// ----- rtl/core/hse_datapath.sv -----
// datapath: block buffer, key and inner registers, sha-1 round engine
`timescale 1ns / 1ps
module hse_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  hse_pkg::cmd_t     cmd,
	input  logic [7:0]        in_byte,
	input  logic [2:0]        word_sel,
	output hse_pkg::status_t  status,
	output logic [31:0]       chain_word
);
	logic [511:0] buf_q;
	logic [511:0] key_q;
	logic [159:0] inner_q;
	logic [7:0]   hold_q;
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [63:0]  len_q;
	logic [5:0]   fill_q;
	logic [6:0]   rnd_q;
	logic         busy_q;

	logic [7:0]  key_byte, byte_sel, len_byte;
	logic [2:0]  ridx;
	logic        count_len;
	logic [31:0] f, k, w, t, new_w;

	assign key_byte = key_q[511:504];
	assign ridx = 3'd7 - cmd.idx;
	assign len_byte = len_q[{ridx, 3'b000} +: 8];

	always_comb begin
		count_len = 1'b1;
		unique case (cmd.src)
			hse_pkg::SRC_IN:    byte_sel = in_byte;
			hse_pkg::SRC_HOLD:  byte_sel = hold_q;
			hse_pkg::SRC_KEY:   byte_sel = key_byte;
			hse_pkg::SRC_KEY_I: byte_sel = key_byte ^ hse_pkg::IPAD;
			hse_pkg::SRC_KEY_O: byte_sel = key_byte ^ hse_pkg::OPAD;
			hse_pkg::SRC_INNER: byte_sel = inner_q[159:152];
			hse_pkg::SRC_PAD80: begin
				byte_sel = hse_pkg::PAD_MARK;
				count_len = 1'b0;
			end
			hse_pkg::SRC_LEN: begin
				byte_sel = len_byte;
				count_len = 1'b0;
			end
			default: begin
				byte_sel = 8'h00;
				count_len = 1'b0;
			end
		endcase
	end

	// round logic: schedule word is always the head of the buffer
	assign w = buf_q[511:480];
	assign new_w = {(buf_q[511-32*13 -: 32] ^ buf_q[511-32*8 -: 32] ^
		buf_q[511-32*2 -: 32] ^ w)} << 1 |
		{31'd0, (buf_q[511-32*13] ^ buf_q[511-32*8] ^ buf_q[511-32*2] ^ w[31])};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = hse_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = hse_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = hse_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = hse_pkg::K3;
		end
	end
	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= 7'd0;
			fill_q <= 6'd0;
			len_q <= 64'd0;
			h_q[0] <= hse_pkg::IV0;
			h_q[1] <= hse_pkg::IV1;
			h_q[2] <= hse_pkg::IV2;
			h_q[3] <= hse_pkg::IV3;
			h_q[4] <= hse_pkg::IV4;
		end else begin
			if (cmd.hash_start) begin
				h_q[0] <= hse_pkg::IV0;
				h_q[1] <= hse_pkg::IV1;
				h_q[2] <= hse_pkg::IV2;
				h_q[3] <= hse_pkg::IV3;
				h_q[4] <= hse_pkg::IV4;
				len_q <= 64'd0;
				fill_q <= 6'd0;
			end else if (cmd.absorb) begin
				fill_q <= fill_q + 6'd1;
				if (count_len) begin
					len_q <= len_q + 64'd8;
				end
				if (fill_q == 6'd63) begin
					busy_q <= 1'b1;
					rnd_q <= 7'd0;
				end
			end else if (busy_q) begin
				if (rnd_q == hse_pkg::ADD_ROUND) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					busy_q <= 1'b0;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			buf_q <= {buf_q[503:0], byte_sel};
			if (fill_q == 6'd63) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end else if (busy_q && rnd_q <= hse_pkg::LAST_ROUND) begin
			buf_q <= {buf_q[479:0], new_w};
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.key_load_digest) begin
			key_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], 352'd0};
		end else if (cmd.key_shift_in) begin
			key_q <= {key_q[503:0], in_byte};
		end else if (cmd.key_shift_zero) begin
			key_q <= {key_q[503:0], 8'h00};
		end else if (cmd.absorb && (cmd.src == hse_pkg::SRC_KEY ||
				cmd.src == hse_pkg::SRC_KEY_I || cmd.src == hse_pkg::SRC_KEY_O)) begin
			key_q <= {key_q[503:0], key_byte};
		end
		if (cmd.inner_save) begin
			inner_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
		end else if (cmd.absorb && cmd.src == hse_pkg::SRC_INNER) begin
			inner_q <= {inner_q[151:0], 8'h00};
		end
		if (cmd.hold_load) begin
			hold_q <= in_byte;
		end
	end

	assign status.busy = busy_q;
	assign status.fill = fill_q;
	assign chain_word = (word_sel < 3'd5) ? h_q[word_sel] : 32'd0;
endmodule

// ----- rtl/core/hse_ctrl.sv -----
// controller: message sequencing state machine
`timescale 1ns / 1ps
module hse_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             is_key,
	input  logic             end_of_part,
	input  logic             carries_none,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       word_sel,
	input  hse_pkg::status_t status,
	output hse_pkg::cmd_t    cmd
);
	hse_pkg::state_t state_q, state_d;
	hse_pkg::ctx_t   ctx_q, ctx_d;
	logic [6:0] kcnt_q, kcnt_d;
	logic [5:0] cnt_q, cnt_d;
	logic       hlast_q, hlast_d;
	logic       acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hse_pkg::S_KEY;
			ctx_q <= hse_pkg::CTX_INNER;
			kcnt_q <= 7'd0;
			cnt_q <= 6'd0;
			hlast_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctx_q <= ctx_d;
			kcnt_q <= kcnt_d;
			cnt_q <= cnt_d;
			hlast_q <= hlast_d;
		end
	end

	assign in_ready = (state_q == hse_pkg::S_KEY || state_q == hse_pkg::S_DATA) && !status.busy;
	assign acc = in_valid && in_ready;
	assign word_sel = cnt_q[2:0];
	assign out_valid = (state_q == hse_pkg::S_OUT);

	always_comb begin
		state_d = state_q;
		ctx_d = ctx_q;
		kcnt_d = kcnt_q;
		cnt_d = cnt_q;
		hlast_d = hlast_q;
		cmd = '0;
		cmd.src = hse_pkg::SRC_IN;
		cmd.idx = cnt_q[2:0];
		unique case (state_q)
			hse_pkg::S_KEY: begin
				if (acc && is_key) begin
					if (!carries_none) begin
						if (kcnt_q < hse_pkg::KEY_FULL) begin
							cmd.key_shift_in = 1'b1;
							kcnt_d = kcnt_q + 7'd1;
						end else if (kcnt_q == hse_pkg::KEY_FULL) begin
							cmd.hash_start = 1'b1;
							cmd.hold_load = 1'b1;
							hlast_d = end_of_part;
							cnt_d = 6'd0;
							state_d = hse_pkg::S_LKEY;
						end else begin
							cmd.absorb = 1'b1;
						end
					end
					if (end_of_part && !(!carries_none && kcnt_q == hse_pkg::KEY_FULL)) begin
						if (kcnt_q == hse_pkg::KEY_LONG) begin
							ctx_d = hse_pkg::CTX_LONGKEY;
							state_d = hse_pkg::S_F80;
						end else begin
							state_d = hse_pkg::S_KPAD;
						end
					end
				end
			end
			hse_pkg::S_KPAD: begin
				if (kcnt_q == hse_pkg::KEY_FULL) begin
					cmd.hash_start = 1'b1;
					cnt_d = 6'd0;
					state_d = hse_pkg::S_INNER;
				end else begin
					cmd.key_shift_zero = 1'b1;
					kcnt_d = kcnt_q + 7'd1;
				end
			end
			hse_pkg::S_LKEY: begin
				if (!status.busy) begin
					cmd.absorb = 1'b1;
					cmd.src = hse_pkg::SRC_KEY;
					cnt_d = cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_d = hse_pkg::S_LBYTE;
					end
				end
			end
			hse_pkg::S_LBYTE: begin
				if (!status.busy) begin
					cmd.absorb = 1'b1;
					cmd.src = hse_pkg::SRC_HOLD;
					kcnt_d = hse_pkg::KEY_LONG;
					if (hlast_q) begin
						ctx_d = hse_pkg::CTX_LONGKEY;
						state_d = hse_pkg::S_F80;
					end else begin
						state_d = hse_pkg::S_KEY;
					end
				end
			end
			hse_pkg::S_INNER: begin
				if (!status.busy) begin
					cmd.absorb = 1'b1;
					cmd.src = hse_pkg::SRC_KEY_I;
					cnt_d = cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_d = hse_pkg::S_DATA;
					end
				end
			end
			hse_pkg::S_DATA: begin
				if (acc && !is_key) begin
					cmd.absorb = !carries_none;
					if (end_of_part) begin
						ctx_d = hse_pkg::CTX_INNER;
						state_d = hse_pkg::S_F80;
					end
				end
			end
			hse_pkg::S_OKEY: begin
				if (!status.busy) begin
					cmd.absorb = 1'b1;
					cmd.src = hse_pkg::SRC_KEY_O;
					cnt_d = cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						cnt_d = 6'd0;
						state_d = hse_pkg::S_OIN;
					end
				end
			end
			hse_pkg::S_OIN: begin
				if (!status.busy) begin
					cmd.absorb = 1'b1;
					cmd.src = hse_pkg::SRC_INNER;
					cnt_d = cnt_q + 6'd1;
					if (cnt_q == 6'd19) begin
						ctx_d = hse_pkg::CTX_OUTER;
						state_d = hse_pkg::S_F80;
					end
				end
			end
			hse_pkg::S_F80: begin
				if (!status.busy) begin
					cmd.absorb = 1'b1;
					cmd.src = hse_pkg::SRC_PAD80;
					state_d = hse_pkg::S_FZERO;
				end
			end
			hse_pkg::S_FZERO: begin
				if (!status.busy) begin
					if (status.fill == hse_pkg::LEN_SLOT) begin
						cnt_d = 6'd0;
						state_d = hse_pkg::S_FLEN;
					end else begin
						cmd.absorb = 1'b1;
						cmd.src = hse_pkg::SRC_ZERO;
					end
				end
			end
			hse_pkg::S_FLEN: begin
				cmd.absorb = 1'b1;
				cmd.src = hse_pkg::SRC_LEN;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd7) begin
					state_d = hse_pkg::S_FWAIT;
				end
			end
			hse_pkg::S_FWAIT: begin
				if (!status.busy) begin
					cnt_d = 6'd0;
					unique case (ctx_q)
						hse_pkg::CTX_LONGKEY: begin
							cmd.key_load_digest = 1'b1;
							cmd.hash_start = 1'b1;
							kcnt_d = hse_pkg::KEY_FULL;
							state_d = hse_pkg::S_INNER;
						end
						hse_pkg::CTX_INNER: begin
							cmd.inner_save = 1'b1;
							cmd.hash_start = 1'b1;
							state_d = hse_pkg::S_OKEY;
						end
						default: state_d = hse_pkg::S_OUT;
					endcase
				end
			end
			hse_pkg::S_OUT: begin
				if (out_ready) begin
					cnt_d = cnt_q + 6'd1;
					if (cnt_q == 6'd4) begin
						cnt_d = 6'd0;
						kcnt_d = 7'd0;
						state_d = hse_pkg::S_KEY;
					end
				end
			end
			default: state_d = hse_pkg::S_KEY;
		endcase
	end
endmodule

// ----- rtl/core/hmac_sha1_engine.sv -----
// top level: hmac-sha1 engine, controller joined to datapath
`timescale 1ns / 1ps
// usage
// - in: one transfer per key or data byte; is_key picks the part, end_of_part
//   closes it, carries_none closes an empty part without a byte
// - items of the wrong part are taken and dropped
// - ready is held low while a 64-byte block is compressed (80 rounds of the
//   single round unit, then the chaining add) and while padding, the key
//   block and the outer hash are worked through
// - each byte is absorbed as it is taken; every 64 bytes add a compression
// - a key of 64 bytes or less is zero filled to 64 bytes, then the inner key
//   block is absorbed and compressed; a longer key is hashed first
// - after the last data item: inner padding, outer key block (64 bytes),
//   inner digest (20 bytes), outer padding, then the first word; the wait
//   depends on how full the last data block is
// - out: five transfers, word 0 most significant, final_word on word 4;
//   a stalled receiver simply holds the engine until all five are taken
// - reset: asynchronous, low active; back to waiting for key bytes with the
//   chaining words at the sha-1 initial values
module hmac_sha1_engine (
	input logic     clk,
	input logic     arst_n,
	hse_in_if.sink  in,
	hse_out_if.source out
);
	hse_pkg::cmd_t    cmd;
	hse_pkg::status_t status;
	logic [2:0]       word_sel;
	logic [31:0]      chain_word;

	// sequencing of key, inner, outer hashes and padding
	hse_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in.valid),
		.in_ready     (in.ready),
		.is_key       (in.is_key),
		.end_of_part  (in.end_of_part),
		.carries_none (in.carries_none),
		.out_valid    (out.valid),
		.out_ready    (out.ready),
		.word_sel     (word_sel),
		.status       (status),
		.cmd          (cmd)
	);

	// buffers and sha-1 round engine
	hse_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_byte    (in.data_value),
		.word_sel   (word_sel),
		.status     (status),
		.chain_word (chain_word)
	);

	// chaining words stay still while the digest is read out
	assign out.digest_word = chain_word;
	assign out.word_number = word_sel;
	assign out.final_word  = (word_sel == 3'd4);
endmodule
